/* rtl/sqpc_pkg.sv */
// ----------------------------------------------------------------------------
// sqpc_pkg
// Shared types and constants of the stack, queue and priority queue checker.
// ----------------------------------------------------------------------------
package sqpc_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int VERDICT_W = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_STACK  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_QUEUE  = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_PRIO   = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_UNSURE = 3'd4;

    typedef struct packed {
        logic latch;
        logic exec;
        logic pop_cmp;
        logic ins;
        logic ins_last;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             ins_lt;
        logic             idx_one;
    } stat_t;

endpackage

/* rtl/sqpc_ram.sv */
// ----------------------------------------------------------------------------
// sqpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sqpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/sqpc_ctrl.sv */
// ----------------------------------------------------------------------------
// sqpc_ctrl
// Controller: sequences each request through execute, compare or insertion
// steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module sqpc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  sqpc_pkg::stat_t stat,
    output sqpc_pkg::ctrl_t ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_POPC = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_DONE;
                if (stat.cmd == sqpc_pkg::CMD_PUSH && !stat.full && !stat.empty)
                begin
                    state_next = ST_INS;
                end
                else if (stat.cmd == sqpc_pkg::CMD_POP && !stat.empty)
                begin
                    state_next = ST_POPC;
                end
            end
            ST_POPC:
            begin
                ctl.pop_cmp = 1'b1;
                state_next  = ST_DONE;
            end
            ST_INS:
            begin
                ctl.ins = 1'b1;
                if (!stat.ins_lt)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.idx_one)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                ctl.ins_last = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

/* rtl/sqpc_dp.sv */
// ----------------------------------------------------------------------------
// sqpc_dp
// Datapath: the three stores, their pointers, the sticky flags and the
// result register.
// ----------------------------------------------------------------------------
module sqpc_dp #(
    parameter int DEPTH = sqpc_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sqpc_pkg::CMD_W-1:0]          cmd,
    input  logic signed [sqpc_pkg::DATA_W-1:0]  value,
    input  sqpc_pkg::ctrl_t                     ctl,
    output sqpc_pkg::stat_t                     stat,
    output logic [7:0]                          result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = sqpc_pkg::DATA_W;

    logic [sqpc_pkg::CMD_W-1:0] cmd_reg;
    logic [DW-1:0]              val_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [2:0]                 flags_reg, flags_next;
    logic                       ovf_reg, ovf_next;
    logic [7:0]                 result_reg;

    logic          lifo_we, fifo_we, sort_we, lifo_re, fifo_re, sort_re;
    logic [AW-1:0] lifo_waddr, sort_waddr, lifo_raddr, sort_raddr;
    logic [DW-1:0] sort_wdata;
    logic [DW-1:0] lifo_rd, fifo_rd, sort_rd;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] top_addr;
    logic [sqpc_pkg::VERDICT_W-1:0] verdict;

    assign count_dec    = count_reg - 1'b1;
    assign top_addr     = count_dec[AW-1:0];
    assign stat.cmd     = cmd_reg;
    assign stat.full    = (count_reg == CW'(DEPTH));
    assign stat.empty   = (count_reg == '0);
    assign stat.ins_lt  = $signed(val_reg) < $signed(sort_rd);
    assign stat.idx_one = (idx_reg == AW'(1));
    assign result       = result_reg;

    sqpc_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_lifo (
        .clk(clk), .wr_en(lifo_we), .wr_addr(lifo_waddr), .wr_data(val_reg),
        .rd_en(lifo_re), .rd_addr(lifo_raddr), .rd_data(lifo_rd)
    );

    sqpc_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_fifo (
        .clk(clk), .wr_en(fifo_we), .wr_addr(tail_reg), .wr_data(val_reg),
        .rd_en(fifo_re), .rd_addr(head_reg), .rd_data(fifo_rd)
    );

    sqpc_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_sort (
        .clk(clk), .wr_en(sort_we), .wr_addr(sort_waddr), .wr_data(sort_wdata),
        .rd_en(sort_re), .rd_addr(sort_raddr), .rd_data(sort_rd)
    );

    always_comb
    begin
        lifo_we    = 1'b0;
        fifo_we    = 1'b0;
        sort_we    = 1'b0;
        lifo_re    = 1'b0;
        fifo_re    = 1'b0;
        sort_re    = 1'b0;
        lifo_waddr = count_reg[AW-1:0];
        lifo_raddr = top_addr;
        sort_waddr = idx_reg;
        sort_wdata = val_reg;
        sort_raddr = top_addr;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        idx_next   = idx_reg;
        flags_next = flags_reg;
        ovf_next   = ovf_reg;
        if (ctl.exec)
        begin
            ovf_next = 1'b0;
            case (cmd_reg)
                sqpc_pkg::CMD_PUSH:
                begin
                    if (stat.full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        lifo_we    = 1'b1;
                        fifo_we    = 1'b1;
                        tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        idx_next   = count_reg[AW-1:0];
                        if (stat.empty)
                        begin
                            sort_we    = 1'b1;
                            sort_waddr = '0;
                        end
                        else
                        begin
                            sort_re = 1'b1;
                        end
                    end
                end
                sqpc_pkg::CMD_POP:
                begin
                    if (stat.empty)
                    begin
                        flags_next = 3'b000;
                    end
                    else
                    begin
                        lifo_re    = 1'b1;
                        fifo_re    = 1'b1;
                        sort_re    = 1'b1;
                        count_next = count_dec;
                        head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    end
                end
                sqpc_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    flags_next = 3'b111;
                end
                default:
                begin
                    flags_next = flags_reg;
                end
            endcase
        end
        if (ctl.pop_cmp)
        begin
            flags_next[0] = flags_reg[0] && (lifo_rd == val_reg);
            flags_next[1] = flags_reg[1] && (fifo_rd == val_reg);
            flags_next[2] = flags_reg[2] && (sort_rd == val_reg);
        end
        if (ctl.ins)
        begin
            sort_we = 1'b1;
            if (stat.ins_lt)
            begin
                sort_wdata = sort_rd;
                idx_next   = idx_reg - 1'b1;
                sort_raddr = idx_reg - AW'(2);
                sort_re    = !stat.idx_one;
            end
        end
        if (ctl.ins_last)
        begin
            sort_we    = 1'b1;
            sort_waddr = '0;
        end
    end

    always_comb
    begin
        unique case (flags_reg)
            3'b000:                       verdict = sqpc_pkg::VERDICT_NONE;
            3'b001:                       verdict = sqpc_pkg::VERDICT_STACK;
            3'b010:                       verdict = sqpc_pkg::VERDICT_QUEUE;
            3'b100:                       verdict = sqpc_pkg::VERDICT_PRIO;
            default:                      verdict = sqpc_pkg::VERDICT_UNSURE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= cmd;
            val_reg <= value;
        end
        idx_reg <= idx_next;
        ovf_reg <= ovf_next;
        if (ctl.load_out)
        begin
            result_reg <= {1'b0, ovf_reg, verdict, flags_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            flags_reg <= 3'b111;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            flags_reg <= flags_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Store count exceeds depth.");

    a_ins_index: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |-> (idx_reg != '0) && ({1'b0, idx_reg} < {1'b0, count_reg}))
        else $error("Insertion index out of range.");

    a_pop_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_cmp |-> (count_reg != CW'(DEPTH)) && !ovf_reg)
        else $error("Pop compare after inconsistent count.");

endmodule

/* rtl/stack_queue_priority_trace_checker.sv */
// ----------------------------------------------------------------------------
// stack_queue_priority_trace_checker
// Checks a push/pop trace against stack, queue and max-priority order.
// ----------------------------------------------------------------------------
// Each request is a push, a pop with an expected value, or a clear, and gives
// one result with three sticky consistency flags, a verdict and an overflow
// bit. A request is taken only when the previous one is finished. A clear, a
// pop from empty stores, a dropped push, an unused command or a push into
// empty stores goes from the execute step straight to the final step; a pop
// adds a compare step, and any other push adds insertion steps that move each
// stored entry greater than the pushed value up one place, since the sorted
// store shifts one entry per cycle through its single write port. A result
// that is not taken holds the next request in its final step until it is.
module stack_queue_priority_trace_checker #(
    parameter int DEPTH = sqpc_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // stack_ok, queue_ok, prio_ok, verdict, overflow, pad
);

    sqpc_pkg::ctrl_t ctl;
    sqpc_pkg::stat_t stat;

    sqpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .ctl(ctl)
    );

    sqpc_dp #(.DEPTH(DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(s_tuser), .value(s_tdata),
        .ctl(ctl), .stat(stat), .result(m_tdata)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the stack, queue and priority queue trace checker.
// ----------------------------------------------------------------------------
// Requests are push, pop and clear traces that follow stack, queue or priority
// order with occasional faults, plus noise and a run that fills the stores.
// A scoreboard keeps its own three stores and flags, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

class trace_scoreboard;
    logic signed [31:0] lifo[$];
    logic signed [31:0] fifo[$];
    logic signed [31:0] sorted[$];
    logic [2:0]         flags;
    logic [7:0]         pending[$];
    int                 errors;

    function void clear_all();
        lifo.delete();
        fifo.delete();
        sorted.delete();
        flags = 3'b111;
    endfunction

    function void note(logic [1:0] cmd, logic signed [31:0] v);
        logic ovf;
        int   pos;
        int   n;
        logic [2:0] verdict;
        ovf = 1'b0;
        if (cmd == sqpc_pkg::CMD_PUSH)
        begin
            if (lifo.size() >= sqpc_pkg::DEPTH_DEF)
            begin
                ovf = 1'b1;
            end
            else
            begin
                lifo.push_back(v);
                fifo.push_back(v);
                pos = sorted.size();
                while (pos > 0 && v < sorted[pos-1]) pos--;
                sorted.insert(pos, v);
            end
        end
        else if (cmd == sqpc_pkg::CMD_POP)
        begin
            if (lifo.size() == 0)
            begin
                flags = 3'b000;
            end
            else
            begin
                if (lifo.pop_back() != v) flags[0] = 1'b0;
                if (fifo.pop_front() != v) flags[1] = 1'b0;
                if (sorted.pop_back() != v) flags[2] = 1'b0;
            end
        end
        else if (cmd == sqpc_pkg::CMD_CLEAR)
        begin
            clear_all();
        end
        n = flags[0] + flags[1] + flags[2];
        if (n == 0) verdict = sqpc_pkg::VERDICT_NONE;
        else if (n > 1) verdict = sqpc_pkg::VERDICT_UNSURE;
        else if (flags[0]) verdict = sqpc_pkg::VERDICT_STACK;
        else if (flags[1]) verdict = sqpc_pkg::VERDICT_QUEUE;
        else verdict = sqpc_pkg::VERDICT_PRIO;
        pending.push_back({1'b0, ovf, verdict, flags[2], flags[1], flags[0]});
    endfunction

    function void check(logic [7:0] got);
        logic [7:0] want;
        if (pending.size() == 0)
        begin
            $error("result 0x%02h arrived with no request outstanding", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[0] !== want[0])
        begin
            $error("stack_ok: expected %0d, actual %0d", want[0], got[0]);
            errors++;
        end
        if (got[1] !== want[1])
        begin
            $error("queue_ok: expected %0d, actual %0d", want[1], got[1]);
            errors++;
        end
        if (got[2] !== want[2])
        begin
            $error("prio_ok: expected %0d, actual %0d", want[2], got[2]);
            errors++;
        end
        if (got[5:3] !== want[5:3])
        begin
            $error("verdict: expected %0d, actual %0d", want[5:3], got[5:3]);
            errors++;
        end
        if (got[6] !== want[6])
        begin
            $error("overflow: expected %0d, actual %0d", want[6], got[6]);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    trace_scoreboard sb;
    int burst_left;
    int sent;
    int long_hold;

    stack_queue_priority_trace_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send(logic [1:0] cmd, logic signed [31:0] v);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        sb.note(cmd, v);
        sent++;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: rand_value = $signed($urandom_range(0, 7)) - 4;
            1: rand_value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: rand_value = $urandom;
        endcase
    endfunction

    task automatic run_trace();
        int kind;
        int steps;
        logic signed [31:0] v;
        kind  = $urandom_range(0, 2);
        steps = $urandom_range(1, 24);
        for (int i = 0; i < steps; i++)
        begin
            if (sb.lifo.size() == 0 || $urandom_range(0, 1))
            begin
                send(sqpc_pkg::CMD_PUSH, rand_value());
            end
            else
            begin
                case (kind)
                    0: v = sb.lifo[$];
                    1: v = sb.fifo[0];
                    default: v = sb.sorted[$];
                endcase
                if ($urandom_range(0, 14) == 0) v = rand_value();
                send(sqpc_pkg::CMD_POP, v);
            end
        end
        while (sb.lifo.size() > 0)
        begin
            case (kind)
                0: v = sb.lifo[$];
                1: v = sb.fifo[0];
                default: v = sb.sorted[$];
            endcase
            send(sqpc_pkg::CMD_POP, v);
        end
        if ($urandom_range(0, 3) == 0) send(sqpc_pkg::CMD_POP, rand_value());
        if ($urandom_range(0, 3) != 0) send(sqpc_pkg::CMD_CLEAR, rand_value());
    endtask

    initial
    begin
        sb = new();
        sb.clear_all();
        sb.errors  = 0;
        burst_left = 0;
        sent       = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = sqpc_pkg::CMD_PUSH;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(sqpc_pkg::CMD_POP, 32'sd5);
        send(sqpc_pkg::CMD_CLEAR, 32'sd0);
        send(sqpc_pkg::CMD_PUSH, 32'sh7FFFFFFF);
        send(sqpc_pkg::CMD_PUSH, 32'sh80000000);
        send(sqpc_pkg::CMD_PUSH, 32'sd0);
        send(sqpc_pkg::CMD_PUSH, -32'sd1);
        send(sqpc_pkg::CMD_PUSH, 32'sd0);
        send(CMD_UNUSED, 32'shFFFFFFFF);
        send(sqpc_pkg::CMD_POP, 32'sh7FFFFFFF);
        send(sqpc_pkg::CMD_POP, 32'sd0);
        send(sqpc_pkg::CMD_POP, 32'sd0);
        send(sqpc_pkg::CMD_POP, -32'sd1);
        send(sqpc_pkg::CMD_POP, 32'sh80000000);
        send(sqpc_pkg::CMD_POP, 32'sd0);
        send(sqpc_pkg::CMD_CLEAR, 32'shFFFFFFFF);
        send(sqpc_pkg::CMD_PUSH, 32'sd3);
        send(sqpc_pkg::CMD_PUSH, 32'sd9);
        send(sqpc_pkg::CMD_POP, 32'sd3);
        send(sqpc_pkg::CMD_POP, 32'sd9);
        send(sqpc_pkg::CMD_PUSH, 32'sd2);
        send(sqpc_pkg::CMD_POP, 32'sd2);
        send(sqpc_pkg::CMD_CLEAR, 32'sd0);

        while (sent < 1700)
        begin
            if (sent > 400 && sent < 500 && sb.lifo.size() == 0)
            begin
                for (int i = 0; i < sqpc_pkg::DEPTH_DEF; i++)
                begin
                    send(sqpc_pkg::CMD_PUSH, i - 512);
                end
                send(sqpc_pkg::CMD_PUSH, 32'sh80000000);
                send(sqpc_pkg::CMD_PUSH, 32'sh7FFFFFFF);
                send(sqpc_pkg::CMD_POP, 32'sd511);
                send(sqpc_pkg::CMD_PUSH, 32'sd600);
                send(sqpc_pkg::CMD_PUSH, 32'sd601);
                send(sqpc_pkg::CMD_CLEAR, 32'sd0);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                send(2'($urandom_range(0, 3)), $urandom);
            end
            else
            begin
                run_trace();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        int mode;
        int left;
        m_tready  = 1'b0;
        long_hold = 0;
        mode      = 0;
        left      = 0;
        forever
        begin
            @(posedge clk);
            if (sent == 300 && long_hold == 0) long_hold = 400;
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 128);
            end
            left--;
            if (long_hold > 1)
            begin
                long_hold--;
                m_tready <= 1'b0;
            end
            else if (mode == 0)
            begin
                m_tready <= 1'b1;
            end
            else if (mode == 1)
            begin
                m_tready <= $urandom_range(0, 1);
            end
            else
            begin
                m_tready <= (left % 4 == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check(m_tdata);
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* stack_queue_priority_trace_checker.f */
rtl/sqpc_pkg.sv
rtl/sqpc_ram.sv
rtl/sqpc_ctrl.sv
rtl/sqpc_dp.sv
rtl/stack_queue_priority_trace_checker.sv
bench/tb_top.sv
